// ===== hdl/efco_pkg.sv =====
// Shared constants and helpers for the event FIFO with overflow coalescing.
package efco_pkg;

  // Field widths fixed by the port definition.
  localparam int unsigned TypeW  = 5;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ErrorW = 8;

  // Largest number of coalescing slots that a 5-bit type can address.
  localparam int unsigned MaxTypes = 32;

  // Parameter defaults.
  localparam int unsigned DefCapacity  = 256;
  localparam int unsigned DefTypeCount = 32;
  localparam int unsigned DefValueBits = 32;

  // Command codes on cmd_i.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [TypeW-1:0] lowest_set(logic [MaxTypes-1:0] v);
    logic [TypeW-1:0] idx;
    idx = '0;
    for (int i = MaxTypes - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = TypeW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/event_fifo_with_coalescing_overflow.sv =====
// Event FIFO with per-type overflow coalescing: ring memory, slot memory and control.
//
// One push or pop command is taken per clock: a command is accepted at a rising edge with
// start_i high and busy_o low, and busy_o is always low, so commands may follow back to
// back. Every command gives exactly one result, on the result ports for one cycle with
// done_o high, in the cycle right after the accepting edge; the receiver cannot stall it,
// so it must take each result in that cycle. The result comes from the registered read
// of the ring memory (CAPACITY entries) and of the coalescing slot memory (TYPE_COUNT
// entries); pointer, count and pending-bit updates happen at the accepting edge, so the
// next command already sees them. A push stores into the ring while it has room
// (push_accepted_o = 1); when the ring is full it overwrites that type's slot and marks
// the type pending (push_accepted_o = 0), or is dropped if the type has no slot. A pop
// returns the oldest ring entry; with the ring empty it returns the lowest pending type's
// slot and clears that bit; with nothing pending, pop_valid_o = 0 and the event fields
// read zero. Neither memory is cleared at reset and no clearing pass runs: an entry is
// only ever read after it was written. Values keep their low VALUE_BITS bits.
module event_fifo_with_coalescing_overflow #(
  parameter int unsigned CAPACITY   = efco_pkg::DefCapacity,
  parameter int unsigned TYPE_COUNT = efco_pkg::DefTypeCount,
  parameter int unsigned VALUE_BITS = efco_pkg::DefValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [efco_pkg::TypeW-1:0]    event_type_i,
  input  logic [efco_pkg::ValueW-1:0]   event_value_i,
  input  logic [efco_pkg::ErrorW-1:0]   event_error_i,
  output logic                          done_o,
  output logic                          push_accepted_o,
  output logic                          pop_valid_o,
  output logic [efco_pkg::TypeW-1:0]    out_type_o,
  output logic [efco_pkg::ValueW-1:0]   out_value_o,
  output logic [efco_pkg::ErrorW-1:0]   out_error_o
);
  import efco_pkg::*;

  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned SlotIdxW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int unsigned StoreW   = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW;
  localparam int unsigned RingW    = TypeW + StoreW + ErrorW;
  localparam int unsigned SlotW    = StoreW + ErrorW;

  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(CAPACITY);
  localparam logic [TypeW:0]   TypeLim  = (TypeW + 1)'(TYPE_COUNT);

  // Memories.
  logic [RingW-1:0] ring_mem [CAPACITY];
  logic [SlotW-1:0] slot_mem [TYPE_COUNT];

  // Control state.
  logic [IdxW-1:0]       head_q, head_d;
  logic [IdxW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [TYPE_COUNT-1:0] pending_q, pending_d;

  // Result stage.
  logic             done_q, done_d;
  logic             push_acc_q, push_acc_d;
  logic             from_ring_q, from_ring_d;
  logic             from_slot_q, from_slot_d;
  logic [TypeW-1:0] slot_type_q, slot_type_d;
  logic [RingW-1:0] ring_rd_q;
  logic [SlotW-1:0] slot_rd_q;

  logic              accept;
  logic              ring_full;
  logic              ring_empty;
  logic              has_slot;
  logic              ring_we;
  logic              ring_re;
  logic              slot_we;
  logic              slot_re;
  logic [TypeW-1:0]  pend_idx;
  logic [StoreW-1:0] value_in;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign value_in = event_value_i[StoreW-1:0];

  assign ring_full  = (count_q == FullCnt);
  assign ring_empty = (count_q == '0);
  assign has_slot   = ({1'b0, event_type_i} < TypeLim);
  assign pend_idx   = lowest_set(MaxTypes'(pending_q));

  // Command decode: at most one of the four memory actions per accepted beat.
  assign ring_we = accept && (cmd_i == CMD_PUSH) && !ring_full;
  assign slot_we = accept && (cmd_i == CMD_PUSH) && ring_full && has_slot;
  assign ring_re = accept && (cmd_i == CMD_POP) && !ring_empty;
  assign slot_re = accept && (cmd_i == CMD_POP) && ring_empty && (pending_q != '0);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    pending_d   = pending_q;
    done_d      = accept;
    push_acc_d  = ring_we;
    from_ring_d = ring_re;
    from_slot_d = slot_re;
    slot_type_d = pend_idx;

    if (ring_we) begin
      tail_d  = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
      count_d = count_q + CntW'(1);
    end
    if (ring_re) begin
      head_d  = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
      count_d = count_q - CntW'(1);
    end
    if (slot_we) begin
      pending_d[event_type_i[SlotIdxW-1:0]] = 1'b1;
    end
    if (slot_re) begin
      pending_d[pend_idx[SlotIdxW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      pending_q   <= '0;
      done_q      <= 1'b0;
      push_acc_q  <= 1'b0;
      from_ring_q <= 1'b0;
      from_slot_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      pending_q   <= pending_d;
      done_q      <= done_d;
      push_acc_q  <= push_acc_d;
      from_ring_q <= from_ring_d;
      from_slot_q <= from_slot_d;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    slot_type_q <= slot_type_d;
  end

  // Ring memory: write at tail, registered read at head.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[tail_q] <= {event_type_i, value_in, event_error_i};
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[head_q];
    end
  end

  // Slot memory: write at the pushed type, registered read at the lowest pending type.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[event_type_i[SlotIdxW-1:0]] <= {value_in, event_error_i};
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[pend_idx[SlotIdxW-1:0]];
    end
  end

  // Result beat; fields read zero unless the beat carries a popped event.
  always_comb begin
    out_type_o  = '0;
    out_value_o = '0;
    out_error_o = '0;
    if (from_ring_q) begin
      out_type_o  = ring_rd_q[RingW-1 -: TypeW];
      out_value_o = ValueW'(ring_rd_q[ErrorW +: StoreW]);
      out_error_o = ring_rd_q[ErrorW-1:0];
    end else if (from_slot_q) begin
      out_type_o  = slot_type_q;
      out_value_o = ValueW'(slot_rd_q[ErrorW +: StoreW]);
      out_error_o = slot_rd_q[ErrorW-1:0];
    end
  end

  assign done_o          = done_q;
  assign push_accepted_o = push_acc_q;
  assign pop_valid_o     = from_ring_q || from_slot_q;

  // Every accepted command gives its result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted command without result beat");

  // A beat is either a push report or a pop report, never both.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_accepted_o && pop_valid_o))
    else $error("push and pop reported together");

  // Fill count never exceeds the ring.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("fill count beyond capacity");

  // Pointers meet exactly when the ring is empty or full.
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> (head_q == tail_q))
    else $error("pointers disagree with fill count");

  // A pop served from the slots clears exactly one pending bit.
  a_slot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_re |=> ($countones(pending_q) + 1 == $past($countones(pending_q))))
    else $error("slot pop did not clear one pending bit");

endmodule

// ===== sim/event_fifo_with_coalescing_overflow_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the event FIFO with per-type overflow coalescing.
module event_fifo_with_coalescing_overflow_tb;
  import efco_pkg::*;

  // Block configuration under test: package defaults.
  localparam int unsigned Capacity  = DefCapacity;
  localparam int unsigned TypeCount = DefTypeCount;
  localparam int unsigned ValueBits = DefValueBits;
  localparam logic [ValueW-1:0] ValueMask = ValueW'((64'd1 << ValueBits) - 64'd1);

  // Watchdog: cycles with no beat accepted on either side before giving up.
  localparam int unsigned StallLimit = 2000;
  // Settling time after the last result; the block answers in the cycle after a command.
  localparam int unsigned TailCycles = 8;

  // One command beat plus its pacing: idle chance per cycle and an optional drain wait.
  typedef struct {
    cmd_e              cmd;
    logic [TypeW-1:0]  ev_type;
    logic [ValueW-1:0] ev_value;
    logic [ErrorW-1:0] ev_error;
    int unsigned       idle_pct;
    bit                wait_drain;
  } event_beat_t;

  // Field order matches the result ports, so a concatenation of the ports packs into it.
  typedef struct packed {
    logic              push_accepted;
    logic              pop_valid;
    logic [TypeW-1:0]  out_type;
    logic [ValueW-1:0] out_value;
    logic [ErrorW-1:0] out_error;
  } fifo_result_t;

  typedef struct packed {
    logic [TypeW-1:0]  ev_type;
    logic [ValueW-1:0] ev_value;
    logic [ErrorW-1:0] ev_error;
  } ring_entry_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  logic              cmd_i         = CMD_PUSH;
  logic [TypeW-1:0]  event_type_i  = '0;
  logic [ValueW-1:0] event_value_i = '0;
  logic [ErrorW-1:0] event_error_i = '0;
  logic              busy_o;
  logic              done_o;
  logic              push_accepted_o;
  logic              pop_valid_o;
  logic [TypeW-1:0]  out_type_o;
  logic [ValueW-1:0] out_value_o;
  logic [ErrorW-1:0] out_error_o;

  event_fifo_with_coalescing_overflow #(
    .CAPACITY  (Capacity),
    .TYPE_COUNT(TypeCount),
    .VALUE_BITS(ValueBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .event_type_i   (event_type_i),
    .event_value_i  (event_value_i),
    .event_error_i  (event_error_i),
    .done_o         (done_o),
    .push_accepted_o(push_accepted_o),
    .pop_valid_o    (pop_valid_o),
    .out_type_o     (out_type_o),
    .out_value_o    (out_value_o),
    .out_error_o    (out_error_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the queue: ring, pointers, fill, coalescing slots, pending mask.
  // ---------------------------------------------------------------------------
  ring_entry_t       ring_mem [Capacity];
  int unsigned       ring_head, ring_tail, ring_fill;
  logic [ValueW-1:0] slot_value [TypeCount];
  logic [ErrorW-1:0] slot_error [TypeCount];
  logic [MaxTypes-1:0] slot_pending = '0;

  // Run statistics for the closing summary.
  int unsigned n_stored, n_coalesced, n_ring_pops, n_slot_pops, n_empty_pops;
  int unsigned max_fill, n_wraps;

  event_beat_t  pending_events[$];   // beats not yet offered to the block
  fifo_result_t expected_results[$]; // predictions waiting for their result beat
  event_beat_t  in_flight;           // beat currently on the command ports

  int unsigned n_accepted = 0;  // command beats taken (updated at the edge, NBA)
  int unsigned n_results  = 0;  // result beats matched (updated at the edge, NBA)
  int unsigned n_errors   = 0;
  int unsigned stall_cycles = 0;
  int unsigned plan_fill = 0;   // ring fill as seen while building the stimulus
  bit          timed_out = 1'b0;
  bit          drv_accept;
  int          drv_outstanding;

  function automatic int unsigned advance(int unsigned idx);
    if (idx == Capacity - 1) begin
      n_wraps++;
      return 0;
    end
    return idx + 1;
  endfunction

  // Applies one command to the shadow state and returns the result it must produce.
  function automatic fifo_result_t predict_result(event_beat_t ev);
    fifo_result_t      r;
    logic [ValueW-1:0] v;
    int                hit;
    r   = '0;
    hit = 0;
    v   = ev.ev_value & ValueMask;
    if (ev.cmd == CMD_PUSH) begin
      if (ring_fill < Capacity) begin
        ring_mem[ring_tail] = '{ev.ev_type, v, ev.ev_error};
        ring_tail           = advance(ring_tail);
        ring_fill++;
        r.push_accepted = 1'b1;
        n_stored++;
        if (ring_fill > max_fill) max_fill = ring_fill;
      end else begin
        // Full ring: last writer wins in the type's slot; types without a slot drop.
        if (ev.ev_type < TypeCount) begin
          slot_value[ev.ev_type]   = v;
          slot_error[ev.ev_type]   = ev.ev_error;
          slot_pending[ev.ev_type] = 1'b1;
        end
        n_coalesced++;
      end
    end else if (ring_fill > 0) begin
      r.pop_valid = 1'b1;
      r.out_type  = ring_mem[ring_head].ev_type;
      r.out_value = ring_mem[ring_head].ev_value;
      r.out_error = ring_mem[ring_head].ev_error;
      ring_head   = advance(ring_head);
      ring_fill--;
      n_ring_pops++;
    end else if (slot_pending != '0) begin
      // Empty ring: lowest-numbered pending type goes first.
      for (int t = TypeCount - 1; t >= 0; t--) begin
        if (slot_pending[t]) hit = t;
      end
      slot_pending[hit] = 1'b0;
      r.pop_valid = 1'b1;
      r.out_type  = TypeW'(hit);
      r.out_value = slot_value[hit];
      r.out_error = slot_error[hit];
      n_slot_pops++;
    end else begin
      n_empty_pops++;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  // Queues one beat. Pacing follows the position in the run: stretches of 90 beats
  // cycle through no idling, an idle chance of 49 percent, and one of 26 percent.
  task automatic add_event(cmd_e cmd, int unsigned ev_type, logic [ValueW-1:0] ev_value,
                           int unsigned ev_error, bit wait_drain = 1'b0);
    event_beat_t b;
    int unsigned pace [3];
    pace         = '{0, 49, 26};
    b.cmd        = cmd;
    b.ev_type    = TypeW'(ev_type);
    b.ev_value   = ev_value;
    b.ev_error   = ErrorW'(ev_error);
    b.idle_pct   = pace[(pending_events.size() / 90) % 3];
    b.wait_drain = wait_drain;
    pending_events.push_back(b);
    if (cmd == CMD_PUSH && plan_fill < Capacity) plan_fill++;
    if (cmd == CMD_POP && plan_fill > 0) plan_fill--;
  endtask

  // Value words lean on the all-zero and all-one corners.
  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ValueW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: books the beat accepted at this edge, then offers the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i       <= 1'b0;
      cmd_i         <= CMD_PUSH;
      event_type_i  <= '0;
      event_value_i <= '0;
      event_error_i <= '0;
      n_accepted    <= 0;
    end else begin
      drv_accept = start_i && !busy_o;
      if (drv_accept) begin
        expected_results.push_back(predict_result(in_flight));
        n_accepted <= n_accepted + 1;
      end
      // Results still owed after this edge; counters are pre-edge values.
      drv_outstanding = int'(n_accepted) + int'(drv_accept) - int'(n_results) - int'(done_o);
      if (drv_accept || !start_i) begin
        if (pending_events.size() != 0
            && !(pending_events[0].wait_drain && drv_outstanding > 0)
            && $urandom_range(99) >= pending_events[0].idle_pct) begin
          in_flight     = pending_events.pop_front();
          start_i       <= 1'b1;
          cmd_i         <= in_flight.cmd;
          event_type_i  <= in_flight.ev_type;
          event_value_i <= in_flight.ev_value;
          event_error_i <= in_flight.ev_error;
        end else begin
          // Idle: junk on the payload so that a payload with start low is shown to be ignored.
          start_i       <= 1'b0;
          cmd_i         <= cmd_e'($urandom_range(1));
          event_type_i  <= TypeW'($urandom);
          event_value_i <= ValueW'($urandom);
          event_error_i <= ErrorW'($urandom);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done beat is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  fifo_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_results <= 0;
    end else if (done_o) begin
      if (n_results >= n_accepted) begin
        $error("result beat with no command outstanding");
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("push_accepted", 64'(want.push_accepted), 64'(push_accepted_o));
        check_field("pop_valid", 64'(want.pop_valid), 64'(pop_valid_o));
        check_field("out_type", 64'(want.out_type), 64'(out_type_o));
        check_field("out_value", 64'(want.out_value), 64'(out_value_o));
        check_field("out_error", 64'(want.out_error), 64'(out_error_o));
        n_results <= n_results + 1;
      end
    end
  end

  // Watchdog: counts cycles in which neither a command nor a result is taken.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;

    // Directed: empty pop out of reset, field extremes, ring pops, back-to-back mix.
    add_event(CMD_POP, 0, '0, 0);
    add_event(CMD_PUSH, 0, '0, 0);
    add_event(CMD_PUSH, 31, '1, 255);
    add_event(CMD_PUSH, 5, 32'hA5A5_A5A5, 8'h5A);
    add_event(CMD_PUSH, 26, 32'h5A5A_5A5A, 8'hA5);
    add_event(CMD_POP, 31, '1, 255);
    add_event(CMD_POP, 0, '0, 0);
    add_event(CMD_POP, 17, 32'h1234_5678, 8'h81);
    add_event(CMD_POP, 0, '0, 0);
    add_event(CMD_POP, 0, '0, 0);           // drained: empty again
    add_event(CMD_PUSH, 1, 32'h8000_0001, 8'h80, 1'b1);
    add_event(CMD_POP, 0, '0, 0);
    add_event(CMD_PUSH, 30, 32'h7FFF_FFFE, 8'h7F);
    add_event(CMD_POP, 0, '0, 0);
    add_event(CMD_POP, 0, '0, 0);

    // Random warm-up, slightly push-heavy.
    for (int k = 0; k < 40; k++) begin
      add_event($urandom_range(99) < 55 ? CMD_PUSH : CMD_POP, $urandom_range(31),
                pick_value(), $urandom_range(255));
    end

    // Fill the ring to the brim; the tail pointer wraps on the way.
    while (plan_fill < Capacity) begin
      add_event(CMD_PUSH, $urandom_range(31), pick_value(), $urandom_range(255));
    end

    // Overflow: pushes land in a few hot slots (repeat overwrites) or anywhere;
    // the odd pop frees one entry so the next push goes back into the ring.
    // The first beat waits for the queue of results to empty out.
    add_event(CMD_PUSH, 2, pick_value(), $urandom_range(255), 1'b1);
    for (int k = 0; k < 30; k++) begin
      add_event($urandom_range(99) < 75 ? CMD_PUSH : CMD_POP,
                $urandom_range(1) ? $urandom_range(3) : $urandom_range(31),
                pick_value(), $urandom_range(255));
    end

    // Drain everything: ring first (head wraps), then the pending slots, then empties.
    n = plan_fill + TypeCount + 4;
    for (int k = 0; k < n; k++) begin
      add_event(CMD_POP, $urandom_range(31), pick_value(), $urandom_range(255));
    end

    // Closing random mix with one more drain pause in the middle.
    for (int k = 0; k < 60; k++) begin
      add_event($urandom_range(99) < 50 ? CMD_PUSH : CMD_POP, $urandom_range(31),
                pick_value(), $urandom_range(255), k == 30);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample at the falling edge so nothing races the drivers.
    while (!timed_out
           && !(pending_events.size() == 0 && !start_i && n_results == n_accepted)) begin
      @(negedge clk_i);
      if (stall_cycles >= StallLimit) timed_out = 1'b1;
    end
    if (!timed_out) begin
      repeat (TailCycles) @(negedge clk_i);
    end

    if (timed_out) begin
      $error("no beat accepted for %0d cycles", StallLimit);
    end
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
    end

    $display("Ran %0d commands: %0d pushes stored, %0d coalesced, %0d ring pops, %0d slot pops,",
             n_accepted, n_stored, n_coalesced, n_ring_pops, n_slot_pops);
    $display("%0d empty pops; ring peaked at %0d of %0d entries, pointers wrapped %0d times.",
             n_empty_pops, max_fill, Capacity, n_wraps);

    if (!timed_out && n_errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
